// ===== rtl/oriented_potential_sor_relaxation_unit_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef ORIENTED_POTENTIAL_SOR_RELAXATION_UNIT_ASSERT_SVH
`define ORIENTED_POTENTIAL_SOR_RELAXATION_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define OPSOR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("opsor assertion failed");

// Next-cycle implication.
`define OPSOR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("opsor assertion failed");

`endif

// ===== rtl/opsor_pkg.sv =====
package opsor_pkg;

  localparam int GRID_ROWS_DEF = 28;
  localparam int GRID_COLS_DEF = 36;

  localparam int CELL_W    = 18;
  localparam int SWEEP_W   = 16;
  localparam int THR_W     = 32;
  localparam int ERR_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [CELL_W-1:0] ONE_Q16 = 18'sd65536;
  localparam logic signed [CELL_W-1:0] CELL_MAX = 18'sd131071;
  localparam logic signed [CELL_W-1:0] CELL_MIN = -18'sd131072;

  // floor(q/5) as ((q + 5*2^23) * ceil(2^30/5)) >> 30, minus 2^23
  localparam logic [26:0] DIV_OFFSET = 27'd41943040;
  localparam logic [27:0] RECIP_5    = 28'd214748365;
  localparam logic signed [26:0] DIV_BIAS = 27'sd8388608;
  localparam logic signed [44:0] ROUND_ADD = 45'sd655360;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_X   = 2'd0,
    REG_WEIGHT_Y   = 2'd1,
    REG_ERR_THR    = 2'd2,
    REG_MAX_SWEEPS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic rd_res;
    logic cell_rd;
    logic old_ld;
    logic nb_rd;
    logic nb_mul;
    logic nb_acc;
    logic dx;
    logic dmul;
    logic dnv;
    logic dsq;
    logic derr;
    logic cell_next;
    logic sweep_end;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] action;
    logic       out_free;
    logic       fixed;
    logic       nb_last;
    logic       cell_last;
    logic       sweep_more;
  } status_t;

endpackage

// ===== rtl/opsor_in_if.sv =====
interface opsor_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [4:0]         row;
  logic [5:0]         col;
  logic signed [17:0] value;

  modport source(output valid, action, row, col, value, input ready);
  modport sink(input valid, action, row, col, value, output ready);
endinterface

// ===== rtl/opsor_out_if.sv =====
interface opsor_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] cell_value;
  logic [15:0]        sweeps_done;
  logic               converged;
  logic [47:0]        last_error;

  modport source(output valid, cell_value, sweeps_done, converged, last_error, input ready);
  modport sink(input valid, cell_value, sweeps_done, converged, last_error, output ready);
endinterface

// ===== rtl/opsor_ctrl.sv =====
module opsor_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  opsor_pkg::status_t st,
  output opsor_pkg::cmd_t    cmd
);
  import opsor_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_RD_WAIT = 14'b00000000000010,
    S_C_RD    = 14'b00000000000100,
    S_C_OLD   = 14'b00000000001000,
    S_N_RD    = 14'b00000000010000,
    S_N_MUL   = 14'b00000000100000,
    S_N_ACC   = 14'b00000001000000,
    S_D_X     = 14'b00000010000000,
    S_D_MUL   = 14'b00000100000000,
    S_D_NV    = 14'b00001000000000,
    S_D_SQ    = 14'b00010000000000,
    S_D_ERR   = 14'b00100000000000,
    S_C_NEXT  = 14'b01000000000000,
    S_SW_END  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.ready  = st.out_free;
        cmd.accept = st.out_free && st.in_valid;
        if (cmd.accept) begin
          case (st.action)
            ACT_RUN:  state_next = S_C_RD;
            ACT_READ: state_next = S_RD_WAIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd.rd_res = 1'b1;
        state_next = S_IDLE;
      end
      S_C_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_C_OLD;
      end
      S_C_OLD: begin
        cmd.old_ld = 1'b1;
        state_next = st.fixed ? S_C_NEXT : S_N_RD;
      end
      S_N_RD: begin
        cmd.nb_rd  = 1'b1;
        state_next = S_N_MUL;
      end
      S_N_MUL: begin
        cmd.nb_mul = 1'b1;
        state_next = S_N_ACC;
      end
      S_N_ACC: begin
        cmd.nb_acc = 1'b1;
        state_next = st.nb_last ? S_D_X : S_N_RD;
      end
      S_D_X: begin
        cmd.dx     = 1'b1;
        state_next = S_D_MUL;
      end
      S_D_MUL: begin
        cmd.dmul   = 1'b1;
        state_next = S_D_NV;
      end
      S_D_NV: begin
        cmd.dnv    = 1'b1;
        state_next = S_D_SQ;
      end
      S_D_SQ: begin
        cmd.dsq    = 1'b1;
        state_next = S_D_ERR;
      end
      S_D_ERR: begin
        cmd.derr   = 1'b1;
        state_next = S_C_NEXT;
      end
      S_C_NEXT: begin
        cmd.cell_next = 1'b1;
        state_next    = st.cell_last ? S_SW_END : S_C_RD;
      end
      S_SW_END: begin
        cmd.sweep_end = 1'b1;
        state_next    = st.sweep_more ? S_C_RD : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/opsor_dp.sv =====
module opsor_dp #(
  parameter int GRID_ROWS = opsor_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = opsor_pkg::GRID_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  opsor_in_if.sink                         in_ch,
  opsor_out_if.source                      out_ch,
  input  logic                             cfg_write,
  input  logic [opsor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opsor_pkg::CFG_W-1:0]      cfg_data,
  input  opsor_pkg::cmd_t                  cmd,
  output opsor_pkg::status_t               st
);
  import opsor_pkg::*;

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);

  // configuration
  logic signed [CELL_W-1:0] wx, wy;
  logic [THR_W-1:0]         thr;
  logic [SWEEP_W-1:0]       maxsw;

  always_ff @(posedge clk) begin
    if (rst) begin
      wx    <= '0;
      wy    <= '0;
      thr   <= 32'd4295;
      maxsw <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_X:   wx    <= $signed(cfg_data[CELL_W-1:0]);
        REG_WEIGHT_Y:   wy    <= $signed(cfg_data[CELL_W-1:0]);
        REG_ERR_THR:    thr   <= cfg_data[THR_W-1:0];
        REG_MAX_SWEEPS: maxsw <= cfg_data[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // grid memory
  logic [CELL_W-1:0]        mem [DEPTH];
  logic signed [CELL_W-1:0] rdata;
  logic [AW-1:0]            raddr, waddr;
  logic [CELL_W-1:0]        wdata;
  logic                     we;

  // sweep position
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [AW-1:0] idx;
  logic [1:0]    k;
  logic          nb_out;

  // arithmetic
  logic signed [CELL_W-1:0] old, nv;
  logic signed [36:0]       prod;
  logic signed [38:0]       acc;
  logic [26:0]              u;
  logic [54:0]              qm;
  logic signed [18:0]       ch;
  logic [37:0]              sq;
  logic [ERR_W-1:0]         err;
  logic [SWEEP_W-1:0]       n;

  logic [12:0]   in_lin;
  logic [AW-1:0] in_addr;
  logic          in_inside, inside_q;
  logic [AW-1:0] nb_addr;
  logic          nb_edge;

  assign in_lin    = 13'(in_ch.row) * 13'(GRID_COLS) + 13'(in_ch.col);
  assign in_addr   = in_lin[AW-1:0];
  assign in_inside = ({2'b00, in_ch.row} < 7'(GRID_ROWS)) && ({1'b0, in_ch.col} < 7'(GRID_COLS));

  always_comb begin
    case (k)
      2'd0: begin
        nb_addr = idx + AW'(1);
        nb_edge = (c == CW'(GRID_COLS - 1));
      end
      2'd1: begin
        nb_addr = idx - AW'(1);
        nb_edge = (c == '0);
      end
      2'd2: begin
        nb_addr = idx - AW'(GRID_COLS);
        nb_edge = (r == '0);
      end
      default: begin
        nb_addr = idx + AW'(GRID_COLS);
        nb_edge = (r == RW'(GRID_ROWS - 1));
      end
    endcase
  end

  always_comb begin
    if (cmd.accept) begin
      raddr = in_addr;
    end else if (cmd.nb_rd) begin
      raddr = nb_addr;
    end else begin
      raddr = idx;
    end
  end

  assign we    = (cmd.accept && in_ch.action == ACT_WRITE && in_inside) || cmd.dsq;
  assign waddr = cmd.accept ? in_addr : idx;
  assign wdata = cmd.accept ? in_ch.value : nv;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= $signed(mem[raddr]);
  end

  // weights: right, left, top, bottom
  logic signed [18:0] wsel;
  logic signed [18:0] wx_e, wy_e;
  logic signed [CELL_W-1:0] nbv;

  assign wx_e = {wx[CELL_W-1], wx};
  assign wy_e = {wy[CELL_W-1], wy};

  always_comb begin
    case (k)
      2'd0:    wsel = 19'sd65536 + wx_e;
      2'd1:    wsel = 19'sd65536 - wx_e;
      2'd2:    wsel = 19'sd65536 + wy_e;
      default: wsel = 19'sd65536 - wy_e;
    endcase
  end

  assign nbv = nb_out ? ONE_Q16 : rdata;

  // relaxation step: x = 9*(S - 4*old*65536) + 655360, d = floor(x / (5*2^18))
  logic signed [44:0] diff, xv;
  logic signed [26:0] dv, nsum;
  logic signed [CELL_W-1:0] nv_sat;
  logic [48:0] esum;
  logic [16:0] n_inc;
  logic [16:0] limit;

  assign diff = 45'(acc) - (45'(old) <<< 18);
  assign xv   = (diff <<< 3) + diff + ROUND_ADD;
  assign dv   = $signed({2'b00, qm[54:30]}) - DIV_BIAS;
  assign nsum = 27'(old) + dv;

  always_comb begin
    if (nsum > 27'(CELL_MAX)) begin
      nv_sat = CELL_MAX;
    end else if (nsum < 27'(CELL_MIN)) begin
      nv_sat = CELL_MIN;
    end else begin
      nv_sat = nsum[CELL_W-1:0];
    end
  end

  assign esum  = {1'b0, err} + 49'(sq);
  assign n_inc = {1'b0, n} + 17'd1;
  assign limit = (maxsw == '0) ? 17'd1 : {1'b0, maxsw};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      inside_q <= in_inside;
    end
    if (cmd.accept && in_ch.action == ACT_RUN) begin
      r   <= '0;
      c   <= '0;
      idx <= '0;
      n   <= '0;
      err <= '0;
    end
    if (cmd.old_ld) begin
      old <= rdata;
      acc <= '0;
      k   <= '0;
    end
    if (cmd.nb_rd) begin
      nb_out <= nb_edge;
    end
    if (cmd.nb_mul) begin
      prod <= wsel * nbv;
    end
    if (cmd.nb_acc) begin
      acc <= acc + 39'(prod);
      k   <= k + 2'd1;
    end
    if (cmd.dx) begin
      u <= 27'(xv[44:18]) + DIV_OFFSET;
    end
    if (cmd.dmul) begin
      qm <= u * RECIP_5;
    end
    if (cmd.dnv) begin
      nv <= nv_sat;
      ch <= 19'(nv_sat) - 19'(old);
    end
    if (cmd.dsq) begin
      sq <= 38'(ch * ch);
    end
    if (cmd.derr) begin
      err <= esum[48] ? {ERR_W{1'b1}} : esum[ERR_W-1:0];
    end
    if (cmd.cell_next) begin
      idx <= idx + AW'(1);
      if (c == CW'(GRID_COLS - 1)) begin
        c <= '0;
        r <= r + RW'(1);
      end else begin
        c <= c + CW'(1);
      end
    end
    if (cmd.sweep_end) begin
      n <= n_inc[SWEEP_W-1:0];
      if (st.sweep_more) begin
        err <= '0;
        r   <= '0;
        c   <= '0;
        idx <= '0;
      end
    end
  end

  // result register
  logic out_valid;
  logic zero_res, run_res;

  assign zero_res = cmd.accept && in_ch.action != ACT_RUN && in_ch.action != ACT_READ;
  assign run_res  = cmd.sweep_end && !st.sweep_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (zero_res || cmd.rd_res || run_res) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (zero_res) begin
      out_ch.cell_value  <= '0;
      out_ch.sweeps_done <= '0;
      out_ch.converged   <= 1'b0;
      out_ch.last_error  <= '0;
    end else if (cmd.rd_res) begin
      out_ch.cell_value  <= inside_q ? rdata : '0;
      out_ch.sweeps_done <= '0;
      out_ch.converged   <= 1'b0;
      out_ch.last_error  <= '0;
    end else if (run_res) begin
      out_ch.cell_value  <= '0;
      out_ch.sweeps_done <= n_inc[SWEEP_W-1:0];
      out_ch.converged   <= (err <= 48'(thr));
      out_ch.last_error  <= err;
    end
  end

  assign out_ch.valid = out_valid;
  assign in_ch.ready  = cmd.ready;

  assign st.in_valid   = in_ch.valid;
  assign st.action     = in_ch.action;
  assign st.out_free   = !out_valid || out_ch.ready;
  assign st.fixed      = (rdata == '0) || (rdata == ONE_Q16);
  assign st.nb_last    = (k == 2'd3);
  assign st.cell_last  = (r == RW'(GRID_ROWS - 1)) && (c == CW'(GRID_COLS - 1));
  assign st.sweep_more = (err > 48'(thr)) && (n_inc < limit);

endmodule

// ===== rtl/oriented_potential_sor_relaxation_unit.sv =====
// Oriented potential relaxation over a GRID_ROWS x GRID_COLS grid of signed Q2.16 cells
// held in one on-chip RAM (no clearing after reset; cells must be written before use,
// which the block does not enforce). A cell write's result is registered in the cycle
// after acceptance; a read passes the RAM output register, then the result register.
// A run performs in-place sweeps in row-major order: a fixed cell (0 or 1.0) is read,
// loaded and skipped; a free cell is read and loaded, its four neighbours are read
// through the grid RAM's one read port, weighted and summed one at a time through the
// shared multiplier, then the divide, write-back and squared-error steps follow; each
// sweep then ends. A new request is taken only once the previous one has finished.
module oriented_potential_sor_relaxation_unit #(
  parameter int GRID_ROWS = opsor_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = opsor_pkg::GRID_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  opsor_in_if.sink                         in_ch,
  opsor_out_if.source                      out_ch,
  input  logic                             cfg_write,
  input  logic [opsor_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opsor_pkg::CFG_W-1:0]      cfg_data
);
  import opsor_pkg::*;

  cmd_t    cmd;
  status_t st;

  opsor_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  opsor_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== rtl/opsor_checker.sv =====
`include "oriented_potential_sor_relaxation_unit_assert.svh"

module opsor_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [17:0] cell_value,
  input logic [15:0]        sweeps_done,
  input logic               converged,
  input logic [47:0]        last_error
);

  `OPSOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_value) && $stable(last_error))
  // a run always reports at least one sweep
  `OPSOR_ASSERT_IMPL(a_conv_has_sweeps, out_valid && converged, sweeps_done != 16'd0)
  `OPSOR_ASSERT_IMPL(a_read_no_run, out_valid && cell_value != 18'sd0, sweeps_done == 16'd0 && !converged && last_error == 48'd0)
  `OPSOR_ASSERT_IMPL(a_nonrun_clean, out_valid && sweeps_done == 16'd0, !converged && last_error == 48'd0)

endmodule

bind oriented_potential_sor_relaxation_unit opsor_checker u_opsor_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cell_value  (out_ch.cell_value),
  .sweeps_done (out_ch.sweeps_done),
  .converged   (out_ch.converged),
  .last_error  (out_ch.last_error)
);
